[rtl/tfbm_pkg.sv]
// shared types, constants and bit-search helpers for the tlsf free-bin manager
`default_nettype none

package tfbm_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned KEY_W  = 33;
  localparam int unsigned POS_W  = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } tfbm_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALIGN,
    ST_ROUND,
    ST_MAP,
    ST_SCAN1,
    ST_SCAN2,
    ST_READ,
    ST_UPD,
    ST_DONE
  } tfbm_state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] request_size;
    logic [DATA_W-1:0] block_addr;
    logic [DATA_W-1:0] next_addr;
  } tfbm_in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [DATA_W-1:0] head_addr;
  } tfbm_out_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [IDX_W-1:0] sl;
  } tfbm_map_upd_t;

  typedef struct packed {
    logic             row_hit;
    logic [IDX_W-1:0] row_sl;
    logic             up_hit;
    logic [IDX_W-1:0] up_fl;
  } tfbm_scan_t;

  function automatic logic [POS_W-1:0] msb_pos(input logic [KEY_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (v[i]) begin
        p = POS_W'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [IDX_W-1:0] lsb_pos(input logic [DATA_W-1:0] v);
    logic [IDX_W-1:0] p;
    p = '0;
    for (int i = DATA_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = IDX_W'(i);
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[rtl/tfbm_bitmaps.sv]
// first- and second-level occupancy bitmaps with set/clear update and bin scan
`default_nettype none

module tfbm_bitmaps #(
  parameter int unsigned FL_COUNT = 25,
  parameter int unsigned SL_LOG2  = 5
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [tfbm_pkg::IDX_W-1:0]    row_fl,
  input  wire [tfbm_pkg::IDX_W-1:0]    scan_sl,
  input  wire tfbm_pkg::tfbm_map_upd_t upd_i,
  output tfbm_pkg::tfbm_scan_t         scan_o
);
  import tfbm_pkg::*;

  localparam int unsigned SL_COUNT = 1 << SL_LOG2;
  localparam int unsigned FLW      = (FL_COUNT > 1) ? $clog2(FL_COUNT) : 1;

  logic [FL_COUNT-1:0] l1_r;
  logic [FL_COUNT-1:0] l1_nxt;
  logic [SL_COUNT-1:0] l2_r [FL_COUNT];
  logic [SL_COUNT-1:0] row;
  logic [SL_COUNT-1:0] row_nxt;
  logic [SL_COUNT-1:0] row_masked;
  logic [FL_COUNT-1:0] up_masked;
  logic [FLW-1:0]      rfl;
  logic [SL_LOG2-1:0]  usl;

  assign rfl = row_fl[FLW-1:0];
  assign usl = upd_i.sl[SL_LOG2-1:0];
  assign row = l2_r[rfl];

  always_comb begin
    row_nxt = row;
    l1_nxt  = l1_r;
    if (upd_i.set) begin
      row_nxt[usl] = 1'b1;
      l1_nxt[rfl]  = 1'b1;
    end else if (upd_i.clr) begin
      row_nxt[usl] = 1'b0;
      if (row_nxt == '0) begin
        l1_nxt[rfl] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= '0;
      for (int i = 0; i < FL_COUNT; i++) begin
        l2_r[i] <= '0;
      end
    end else begin
      l1_r <= l1_nxt;
      if (upd_i.set || upd_i.clr) begin
        l2_r[rfl] <= row_nxt;
      end
    end
  end

  // bins at or above scan_sl in this row, and levels above row_fl
  always_comb begin
    for (int i = 0; i < SL_COUNT; i++) begin
      row_masked[i] = row[i] && (IDX_W'(i) >= scan_sl);
    end
    for (int j = 0; j < FL_COUNT; j++) begin
      up_masked[j] = l1_r[j] && (IDX_W'(j) > row_fl);
    end
    scan_o.row_hit = |row_masked;
    scan_o.row_sl  = lsb_pos(DATA_W'(row_masked));
    scan_o.up_hit  = |up_masked;
    scan_o.up_fl   = lsb_pos(DATA_W'(up_masked));
  end

  a_l1_tracks_row: assert property (@(posedge clk) disable iff (!rst_n)
    (row_fl < IDX_W'(FL_COUNT - 1) || row_fl == IDX_W'(FL_COUNT - 1)) |->
      ((|row) == l1_r[rfl]))
    else $error("level-one bit disagrees with its level-two row");

  a_set_clr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(upd_i.set && upd_i.clr))
    else $error("bitmap set and clear in the same cycle");

  a_set_marks_l1: assert property (@(posedge clk) disable iff (!rst_n)
    upd_i.set |=> (l1_r != '0))
    else $error("level-one map empty after an insert");

endmodule

`default_nettype wire

[rtl/tfbm_head_ram.sv]
// bin head memory with registered read and a clearing sweep after reset
`default_nettype none

module tfbm_head_ram #(
  parameter int unsigned DEPTH = 800,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 32
) (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [DW-1:0] wdata,
  input  wire  [AW-1:0] raddr,
  output logic [DW-1:0] rdata,
  output logic          clr_busy
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;
  logic          clr_busy_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata    = rdata_r;
  assign clr_busy = clr_busy_r;

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_busy_r && we))
    else $error("head write during clearing sweep");

  a_sweep_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_busy_r && $past(clr_busy_r) && $past(rst_n)) |->
      (clr_cnt_r == $past(clr_cnt_r) + 1'b1))
    else $error("clearing sweep skipped an entry");

  a_sweep_ends_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_busy_r) |-> ($past(clr_cnt_r) == AW'(DEPTH - 1)))
    else $error("clearing sweep ended early");

endmodule

`default_nettype wire

[rtl/tlsf_free_bin_matrix.sv]
// top level of the tlsf free-bin manager: sequencer, size mapping and result register
`default_nettype none

// TLSF free-bin manager. After reset the head memory is swept to null, all
// FL_COUNT * 2^SL_LOG2 entries (800 at the defaults); in_ready rises in the
// cycle after the sweep ends. Items are then handled one at a time by a
// sequencer around the head memory, whose read is registered. An insert or
// remove steps through map, read, update, result and idle, or map, result and
// idle when its bin is past the table; a search that finds a bin goes through
// align, round up, map, one or two bitmap scans, read, update, result and
// idle, and one that misses goes from map or a scan on to result; opcode 3
// goes straight to result. The next item is accepted while a finished result
// still waits in the output register; a result that finds that register full
// waits in the result state until the waiting beat is taken. Opcode 3, bins
// past the table and a search that misses return an all-zero result.
module tlsf_free_bin_matrix #(
  parameter int unsigned SL_LOG2    = 5,
  parameter int unsigned FL_COUNT   = 25,
  parameter int unsigned ALIGN_LOG2 = 3,
  parameter int unsigned MIN_BLOCK  = 16,
  parameter int unsigned ADDR_W     = 32
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  input  wire tfbm_pkg::tfbm_in_t in_data,
  output logic                    out_valid,
  input  wire                     out_ready,
  output tfbm_pkg::tfbm_out_t     out_data
);
  import tfbm_pkg::*;

  localparam int unsigned SL_COUNT = 1 << SL_LOG2;
  localparam int unsigned FL_SHIFT = SL_LOG2 + ALIGN_LOG2;
  localparam int unsigned FLW      = (FL_COUNT > 1) ? $clog2(FL_COUNT) : 1;
  localparam int unsigned AW       = FLW + SL_LOG2;
  localparam int unsigned DEPTH    = FL_COUNT * SL_COUNT;
  localparam int unsigned HW       = (ADDR_W < DATA_W) ? ADDR_W : DATA_W;
  localparam logic [KEY_W-1:0] SMALL_SIZE = KEY_W'(1) << FL_SHIFT;
  localparam logic [KEY_W-1:0] ALIGN_MASK = KEY_W'((1 << ALIGN_LOG2) - 1);

  tfbm_state_t state_r;
  tfbm_state_t state_nxt;

  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [HW-1:0]    blk_r;
  logic [HW-1:0]    nxt_addr_r;
  logic [IDX_W-1:0] fl_r;
  logic [IDX_W-1:0] sl_r;
  logic             range_r;
  logic             found_r;
  logic [HW-1:0]    head_r;
  logic             out_valid_r;
  tfbm_out_t        out_data_r;

  // size datapath
  logic [KEY_W-1:0] aligned;
  logic [KEY_W-1:0] clamped;
  logic [POS_W-1:0] key_msb;
  logic [POS_W-1:0] sl_shift;
  logic [KEY_W-1:0] rounded;
  logic [POS_W-1:0] map_f;
  logic [KEY_W-1:0] key_shifted;
  logic [IDX_W-1:0] map_fl;
  logic [IDX_W-1:0] map_sl;
  logic             map_ok;

  // memory and bitmap control
  logic             ram_we;
  logic [HW-1:0]    ram_wdata;
  logic [HW-1:0]    ram_rdata;
  logic [AW-1:0]    bin_addr;
  logic             clr_busy;
  logic             head_match;
  logic [IDX_W-1:0] scan_sl;
  tfbm_map_upd_t    map_upd;
  tfbm_scan_t       scan;
  logic             out_free;

  assign key_msb     = msb_pos(key_r);
  assign sl_shift    = key_msb - POS_W'(SL_LOG2);
  assign aligned     = (key_r + ALIGN_MASK) & ~ALIGN_MASK;
  assign clamped     = (aligned < KEY_W'(MIN_BLOCK)) ? KEY_W'(MIN_BLOCK) : aligned;
  assign rounded     = (key_r < SMALL_SIZE) ? key_r :
                       key_r + ((KEY_W'(1) << sl_shift) - KEY_W'(1));
  assign map_f       = key_msb - POS_W'(FL_SHIFT - 1);
  assign key_shifted = key_r >> sl_shift;

  always_comb begin
    if (key_r < SMALL_SIZE) begin
      map_fl = '0;
      map_sl = IDX_W'(key_r >> ALIGN_LOG2);
      map_ok = 1'b1;
    end else begin
      map_fl = map_f[IDX_W-1:0];
      map_sl = IDX_W'(key_shifted[SL_LOG2-1:0]);
      map_ok = (map_f < POS_W'(FL_COUNT));
    end
  end

  assign bin_addr   = {fl_r[FLW-1:0], sl_r[SL_LOG2-1:0]};
  assign head_match = (ram_rdata == blk_r);
  assign out_free   = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (!clr_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_SEARCH) begin
            state_nxt = ST_ALIGN;
          end else if (in_data.opcode == OP_INSERT || in_data.opcode == OP_REMOVE) begin
            state_nxt = ST_MAP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_ALIGN: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_MAP;
      ST_MAP: begin
        if (!map_ok) begin
          state_nxt = ST_DONE;
        end else if (op_r == OP_SEARCH) begin
          state_nxt = ST_SCAN1;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_SCAN1: begin
        if (scan.row_hit) begin
          state_nxt = ST_READ;
        end else if (scan.up_hit) begin
          state_nxt = ST_SCAN2;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN2: state_nxt = scan.row_hit ? ST_READ : ST_DONE;
      ST_READ:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = blk_r;
    scan_sl     = sl_r;
    map_upd     = '0;
    map_upd.sl  = sl_r;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN2: scan_sl  = '0;
      ST_UPD: begin
        if (op_r == OP_INSERT) begin
          ram_we      = 1'b1;
          map_upd.set = 1'b1;
        end else if (op_r == OP_REMOVE && head_match) begin
          ram_we      = 1'b1;
          ram_wdata   = nxt_addr_r;
          map_upd.clr = (nxt_addr_r == '0);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        op_r       <= in_data.opcode;
        key_r      <= KEY_W'(in_data.request_size);
        blk_r      <= in_data.block_addr[HW-1:0];
        nxt_addr_r <= in_data.next_addr[HW-1:0];
        found_r    <= 1'b0;
      end
      ST_ALIGN: key_r <= clamped;
      ST_ROUND: key_r <= rounded;
      ST_MAP: begin
        fl_r    <= map_fl;
        sl_r    <= map_sl;
        range_r <= map_ok;
      end
      ST_SCAN1: begin
        if (scan.row_hit) begin
          sl_r <= scan.row_sl;
        end else if (scan.up_hit) begin
          fl_r <= scan.up_fl;
        end
      end
      ST_SCAN2: sl_r <= scan.row_sl;
      ST_UPD: begin
        found_r <= 1'b1;
        if (op_r == OP_REMOVE && head_match) begin
          head_r <= nxt_addr_r;
        end else begin
          head_r <= ram_rdata;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r.found        <= found_r;
          out_data_r.first_index  <= found_r ? fl_r : '0;
          out_data_r.second_index <= found_r ? sl_r : '0;
          out_data_r.head_addr    <= found_r ? DATA_W'(head_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  tfbm_head_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (HW)
  ) u_head_ram (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (ram_we),
    .waddr    (bin_addr),
    .wdata    (ram_wdata),
    .raddr    (bin_addr),
    .rdata    (ram_rdata),
    .clr_busy (clr_busy)
  );

  tfbm_bitmaps #(
    .FL_COUNT (FL_COUNT),
    .SL_LOG2  (SL_LOG2)
  ) u_bitmaps (
    .clk     (clk),
    .rst_n   (rst_n),
    .row_fl  (fl_r),
    .scan_sl (scan_sl),
    .upd_i   (map_upd),
    .scan_o  (scan)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !clr_busy)
    else $error("item accepted during clearing sweep");

  a_update_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> range_r)
    else $error("head memory touched for a bin past the table");

  a_write_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> (state_r == ST_DONE))
    else $error("head write not followed by result");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result raised outside the result state");

endmodule

`default_nettype wire
